@@ sv/svo_pkg.sv @@
// Shared types, widths and field offsets of the servo slew and pulse block.
`default_nettype none
package svo_pkg;

    // Field widths
    localparam int JOINT_W   = 4;
    localparam int ANGLE_W   = 18;
    localparam int PULSE_W   = 16;
    localparam int STEP_W    = 16;
    localparam int CHAN_W    = 4;
    localparam int REQ_W     = 2;

    // Joint count limits and default
    localparam int MAX_JOINTS     = 16;
    localparam int NUM_JOINTS_DEF = 4;

    // Snap threshold in angle LSBs
    localparam int SNAP_LSB = 3;

    // Internal arithmetic widths
    localparam int DIFF_W = ANGLE_W + 1;           // angle difference
    localparam int DP_W   = PULSE_W + 1;           // pulse span
    localparam int PROD_W = DIFF_W + DP_W;         // numerator product
    localparam int N2_W   = PROD_W + 2;            // doubled numerator plus range
    localparam int DSR_W  = DIFF_W + 1;            // doubled angle range
    localparam int CNT_W  = $clog2(N2_W + 1);      // divide iteration count
    localparam int SUM_W  = N2_W + 2;              // pulse sum before saturation

    // Slave word layout, lowest bit first
    localparam int S_JOINT_LO = 0;
    localparam int S_ANGLE_LO = S_JOINT_LO + JOINT_W;
    localparam int S_AMIN_LO  = S_ANGLE_LO + ANGLE_W;
    localparam int S_AMAX_LO  = S_AMIN_LO + ANGLE_W;
    localparam int S_PMIN_LO  = S_AMAX_LO + ANGLE_W;
    localparam int S_PMAX_LO  = S_PMIN_LO + PULSE_W;
    localparam int S_STEP_LO  = S_PMAX_LO + PULSE_W;
    localparam int S_CHAN_LO  = S_STEP_LO + STEP_W;
    localparam int S_USED_W   = S_CHAN_LO + CHAN_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Master word layout, lowest bit first
    localparam int M_JOINT_LO = 0;
    localparam int M_CHAN_LO  = M_JOINT_LO + JOINT_W;
    localparam int M_PULSE_LO = M_CHAN_LO + CHAN_W;
    localparam int M_ANGLE_LO = M_PULSE_LO + PULSE_W;
    localparam int M_USED_W   = M_ANGLE_LO + ANGLE_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_SET  = 2'd0,
        REQ_TICK = 2'd1,
        REQ_LOAD = 2'd2
    } t_req;

    // Commands from controller to datapath
    typedef struct packed {
        logic               capture;
        logic               set_tgt;
        logic               load;
        logic               step;
        logic               mul;
        logic               prep;
        logic               div_step;
        logic               emit;
        logic               last;
        logic [JOINT_W-1:0] addr;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [JOINT_W-1:0] joint;
        logic               div_last;
        logic               out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ sv/multi_joint_slew_limited_servo_pulse_top.sv @@
// Top level of the multi-joint slew-limited servo pulse generator.
// Set target and load: the joint is written in the decode state after acceptance; no word results.
// Tick: each joint in turn runs step, multiply, prepare, a 38-step divide and finish;
//   the first word follows the first joint's finish, and finish waits for a free output register.
// Throughput is set by the one-bit-per-cycle divider shared by all joints.
// Reset (synchronous, active low) clears the sequencer, divide counter and output valid only.
`default_nettype none
module multi_joint_slew_limited_servo_pulse_top
    import svo_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // joint, angle, low limit, high limit, low pulse, high pulse, step, channel
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]     i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // joint, channel, pulse, angle
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    svo_ctrl #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    svo_datapath #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

@@ sv/svo_datapath.sv @@
// Joint state registers, slew step, pulse mapping with iterative divider, output register.
`default_nettype none
module svo_datapath
    import svo_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [REQ_W-1:0]     i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic                      o_m_tlast
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // Per-joint state, undefined until loaded
    logic signed [ANGLE_W-1:0] r_cur  [NUM_JOINTS];
    logic signed [ANGLE_W-1:0] r_tgt  [NUM_JOINTS];
    logic signed [ANGLE_W-1:0] r_lo   [NUM_JOINTS];
    logic signed [ANGLE_W-1:0] r_hi   [NUM_JOINTS];
    logic        [PULSE_W-1:0] r_pl   [NUM_JOINTS];
    logic        [PULSE_W-1:0] r_ph   [NUM_JOINTS];
    logic        [STEP_W-1:0]  r_stl  [NUM_JOINTS];
    logic        [CHAN_W-1:0]  r_chn  [NUM_JOINTS];

    // Captured request word
    logic        [REQ_W-1:0]   r_req;
    logic        [JOINT_W-1:0] r_joint;
    logic signed [ANGLE_W-1:0] r_ang;
    logic signed [ANGLE_W-1:0] r_amin;
    logic signed [ANGLE_W-1:0] r_amax;
    logic        [PULSE_W-1:0] r_pmin;
    logic        [PULSE_W-1:0] r_pmax;
    logic        [STEP_W-1:0]  r_step;
    logic        [CHAN_W-1:0]  r_chan;

    // Per-joint work registers
    logic signed [ANGLE_W-1:0] r_new;
    logic signed [DIFF_W-1:0]  r_da;
    logic signed [DP_W-1:0]    r_dp;
    logic signed [DIFF_W-1:0]  r_den;
    logic        [PULSE_W-1:0] r_wpl;
    logic        [CHAN_W-1:0]  r_wch;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_neg;
    logic                      r_zero;
    logic        [N2_W-1:0]    r_dvd;
    logic        [DSR_W-1:0]   r_dsr;
    logic        [DSR_W-1:0]   r_rem;
    logic        [CNT_W-1:0]   r_cnt;

    // Output register
    logic                      r_out_valid;
    logic        [M_TDATA_W-1:0] r_out_data;
    logic                      r_out_last;

    logic [JW-1:0] idx;
    assign idx = i_cmd.addr[JW-1:0];

    // Clamp a new target to the joint limits, low first
    logic signed [ANGLE_W-1:0] clamp_lo;
    logic signed [ANGLE_W-1:0] clamp_ang;
    always_comb begin
        clamp_lo  = (r_ang < r_lo[idx]) ? r_lo[idx] : r_ang;
        clamp_ang = (clamp_lo > r_hi[idx]) ? r_hi[idx] : clamp_lo;
    end

    // Slew one joint toward its target
    logic signed [ANGLE_W-1:0] cur;
    logic signed [ANGLE_W-1:0] tgt;
    logic signed [DIFF_W-1:0]  diff;
    logic        [DIFF_W-1:0]  mag;
    logic        [DIFF_W-1:0]  stl_ext;
    logic        [DIFF_W-1:0]  st;
    logic signed [DIFF_W-1:0]  moved;
    logic                      snap;
    logic signed [ANGLE_W-1:0] new_ang;
    always_comb begin
        cur     = r_cur[idx];
        tgt     = r_tgt[idx];
        diff    = DIFF_W'(tgt) - DIFF_W'(cur);
        mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        snap    = (mag < DIFF_W'(SNAP_LSB));
        stl_ext = DIFF_W'(r_stl[idx]);
        st      = (mag > stl_ext) ? stl_ext : mag;
        moved   = diff[DIFF_W-1] ? (DIFF_W'(cur) - $signed(st))
                                 : (DIFF_W'(cur) + $signed(st));
        new_ang = snap ? tgt : moved[ANGLE_W-1:0];
    end

    // Fold the range sign into the numerator and add half the divisor
    logic                      den_neg;
    logic        [DIFF_W-1:0]  den_abs;
    logic signed [PROD_W:0]    num_s;
    logic signed [N2_W-1:0]    n2;
    always_comb begin
        den_neg = r_den[DIFF_W-1];
        den_abs = den_neg ? DIFF_W'(-r_den) : DIFF_W'(r_den);
        num_s   = den_neg ? -(PROD_W+1)'(r_prod) : (PROD_W+1)'(r_prod);
        n2      = {num_s, 1'b0} + N2_W'(den_abs);
    end

    // One restoring divide step
    logic [DSR_W:0] rem_sh;
    logic           q_bit;
    logic [DSR_W:0] rem_sub;
    always_comb begin
        rem_sh  = {r_rem, r_dvd[N2_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_dsr});
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    // Floor the quotient, add the low pulse and saturate
    logic        [N2_W-1:0]    q_mag;
    logic signed [N2_W:0]      q_s;
    logic signed [SUM_W-1:0]   psum;
    logic        [PULSE_W-1:0] pulse;
    always_comb begin
        q_mag = r_dvd + N2_W'(r_neg && (r_rem != '0));
        q_s   = r_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        psum  = $signed(SUM_W'(r_wpl)) + SUM_W'(q_s);
        if (r_zero) begin
            pulse = r_wpl;
        end else if (psum < 0) begin
            pulse = '0;
        end else if (psum > $signed(SUM_W'({PULSE_W{1'b1}}))) begin
            pulse = '1;
        end else begin
            pulse = psum[PULSE_W-1:0];
        end
    end

    // Capture request, update joint state, run the mapping steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_s_tuser;
            r_joint <= i_s_tdata[S_JOINT_LO +: JOINT_W];
            r_ang   <= i_s_tdata[S_ANGLE_LO +: ANGLE_W];
            r_amin  <= i_s_tdata[S_AMIN_LO +: ANGLE_W];
            r_amax  <= i_s_tdata[S_AMAX_LO +: ANGLE_W];
            r_pmin  <= i_s_tdata[S_PMIN_LO +: PULSE_W];
            r_pmax  <= i_s_tdata[S_PMAX_LO +: PULSE_W];
            r_step  <= i_s_tdata[S_STEP_LO +: STEP_W];
            r_chan  <= i_s_tdata[S_CHAN_LO +: CHAN_W];
        end
        if (i_cmd.set_tgt) begin
            r_tgt[idx] <= clamp_ang;
        end
        if (i_cmd.load) begin
            r_lo[idx]  <= r_amin;
            r_hi[idx]  <= r_amax;
            r_pl[idx]  <= r_pmin;
            r_ph[idx]  <= r_pmax;
            r_stl[idx] <= r_step;
            r_chn[idx] <= r_chan;
            r_cur[idx] <= r_ang;
            r_tgt[idx] <= r_ang;
        end
        if (i_cmd.step) begin
            r_cur[idx] <= new_ang;
            r_new      <= new_ang;
            r_da       <= DIFF_W'(new_ang) - DIFF_W'(r_lo[idx]);
            r_dp       <= $signed(DP_W'(r_ph[idx])) - $signed(DP_W'(r_pl[idx]));
            r_den      <= DIFF_W'(r_hi[idx]) - DIFF_W'(r_lo[idx]);
            r_wpl      <= r_pl[idx];
            r_wch      <= r_chn[idx];
        end
        if (i_cmd.mul) begin
            r_prod <= r_da * r_dp;
        end
        if (i_cmd.prep) begin
            r_neg  <= n2[N2_W-1];
            r_dvd  <= n2[N2_W-1] ? N2_W'(-n2) : N2_W'(n2);
            r_dsr  <= {den_abs, 1'b0};
            r_rem  <= '0;
            r_zero <= (r_den == '0);
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[N2_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_data <= M_TDATA_W'({r_new, pulse, r_wch, i_cmd.addr});
            r_out_last <= i_cmd.last;
        end
    end

    // Divide iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.prep) begin
            r_cnt <= CNT_W'(N2_W);
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Hold a result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.req      = r_req;
    assign o_stat.joint    = r_joint;
    assign o_stat.div_last = (r_cnt == CNT_W'(1));
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // A load leaves the joint at rest on its home angle
    a_load_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cur[$past(idx)] == r_tgt[$past(idx)]))
        else $error("load did not home the joint");

    // A snapping step lands exactly on the target
    a_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && snap) |=> (r_cur[$past(idx)] == r_tgt[$past(idx)]))
        else $error("snap missed the target");

    // The divider runs only with iterations left
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("divide step with no iterations left");

endmodule
`default_nettype wire

@@ sv/svo_ctrl.sv @@
// Sequencer for request decode and the per-joint tick walk.
`default_nettype none
module svo_ctrl
    import svo_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_STEP,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [JOINT_W-1:0] r_idx;
    logic [JOINT_W-1:0] n_idx;

    logic in_range;
    logic last_joint;
    assign in_range   = ({1'b0, i_stat.joint} < (JOINT_W+1)'(NUM_JOINTS));
    assign last_joint = (r_idx == JOINT_W'(NUM_JOINTS - 1));

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.addr = r_idx;
        o_cmd.last = last_joint;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.addr = i_stat.joint;
                n_state    = S_IDLE;
                case (i_stat.req)
                    REQ_SET:  o_cmd.set_tgt = in_range;
                    REQ_LOAD: o_cmd.load    = in_range;
                    REQ_TICK: begin
                        n_idx   = '0;
                        n_state = S_STEP;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (last_joint) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_STEP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and joint counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // Emit only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted over a pending word");

    // The walk never addresses a joint beyond the configured count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ({1'b0, r_idx} < (JOINT_W+1)'(NUM_JOINTS)))
        else $error("joint counter out of range");

    // Finish is entered only from the divider
    a_fin_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_FIN) |-> ($past(r_state) == S_DIV))
        else $error("finish entered without divide");

endmodule
`default_nettype wire
